[hdl/dla_pkg.sv]
// Shared types and constants for the ascending divisor lister.
// No dependencies; the controller, the datapath and the top level import this package.
`default_nettype none
package dla_pkg;

	// Results per run are capped; further divisors are dropped.
	localparam int MAX_RESULTS = 48;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_CHECK,
		ST_POP,
		ST_POPW
	} dla_state_t;

	typedef struct packed {
		logic load;       // take a new number, restart the scan
		logic div_start;  // begin a trial division of the number by the candidate
		logic advance;    // step to the next candidate
		logic emit_cand;  // send the candidate as a divisor
		logic push;       // push the quotient on the cofactor stack
		logic pop_read;   // read the top of the stack and pop it
		logic emit_pop;   // send the popped cofactor
	} dla_cmd_t;

	typedef struct packed {
		logic in_zero;      // incoming number is zero
		logic sq_over;      // candidate squared exceeds the number
		logic div_busy;     // divider still iterating
		logic rem_zero;     // remainder of the last division is zero
		logic quo_ne_cand;  // quotient differs from the candidate
		logic stack_room;   // stack has a free entry
		logic stack_empty;  // no stacked cofactors left
		logic res_room;     // result cap not reached
		logic out_free;     // output register can take a word this cycle
	} dla_status_t;

endpackage
`default_nettype wire

[hdl/dla_in_if.sv]
// Input channel: valid/ready handshake carrying the number to factor.
// No dependencies.
`default_nettype none
interface dla_in_if #(
	parameter int NUMBER_WIDTH = 12
);
	logic                    valid;
	logic                    ready;
	logic [NUMBER_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface
`default_nettype wire

[hdl/dla_out_if.sv]
// Output channel: valid/ready handshake carrying one divisor and its last flag.
// No dependencies.
`default_nettype none
interface dla_out_if #(
	parameter int NUMBER_WIDTH = 12
);
	logic                    valid;
	logic                    ready;
	logic [NUMBER_WIDTH-1:0] divisor;
	logic                    last;

	modport source (output valid, output divisor, output last, input ready);
	modport sink   (input valid, input divisor, input last, output ready);
endinterface
`default_nettype wire

[hdl/dla_datapath.sv]
// Datapath: candidate and square tracking, bit-serial restoring divider,
// cofactor stack memory and output register. Depends on dla_pkg.
`default_nettype none
module dla_datapath #(
	parameter int NUMBER_WIDTH = 12,
	parameter int STACK_DEPTH  = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dla_pkg::dla_cmd_t       cmd,
	output dla_pkg::dla_status_t         status,
	input  wire logic [NUMBER_WIDTH-1:0] number,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [NUMBER_WIDTH-1:0]      out_divisor,
	output logic                         out_last
);
	import dla_pkg::*;

	localparam int W   = NUMBER_WIDTH;
	localparam int CW  = (W + 1) / 2 + 1;
	localparam int SW  = 2 * CW;
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int KW  = $clog2(STACK_DEPTH + 1);
	localparam int DCW = $clog2(W + 1);

	logic [W-1:0]     n_q;
	logic [CW-1:0]    cand_q;
	logic [SW-1:0]    sq_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [DCW-1:0]   dcnt_q;
	logic [KW-1:0]    sp_q;
	logic [RES_W-1:0] rcnt_q;
	logic [W-1:0]     pop_q;
	logic [W-1:0]     mem [STACK_DEPTH];

	logic [W:0]    shifted;
	logic [W:0]    dvs;
	logic [W:0]    diff;
	logic          ge;
	logic [W-1:0]  cand_ext;
	logic [KW-1:0] sp_dec;
	logic          out_valid_q;
	logic [W-1:0]  out_divisor_q;
	logic          out_last_q;

	// One quotient bit per cycle.
	assign shifted  = {rem_q, quo_q[W-1]};
	assign dvs      = (W+1)'(cand_q);
	assign ge       = shifted >= dvs;
	assign diff     = shifted - dvs;
	assign cand_ext = W'(cand_q);
	assign sp_dec   = sp_q - 1'b1;

	always_comb begin
		status.in_zero     = number == '0;
		status.sq_over     = sq_q > SW'(n_q);
		status.div_busy    = dcnt_q != '0;
		status.rem_zero    = rem_q == '0;
		status.quo_ne_cand = quo_q != cand_ext;
		status.stack_room  = sp_q < KW'(STACK_DEPTH);
		status.stack_empty = sp_q == '0;
		status.res_room    = rcnt_q < RES_W'(MAX_RESULTS);
		status.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			sp_q   <= '0;
			rcnt_q <= '0;
		end else begin
			if (cmd.load) begin
				sp_q   <= '0;
				rcnt_q <= '0;
			end else begin
				if (cmd.push)
					sp_q <= sp_q + 1'b1;
				else if (cmd.pop_read)
					sp_q <= sp_dec;
				if (cmd.emit_cand || cmd.emit_pop)
					rcnt_q <= rcnt_q + 1'b1;
			end
			if (cmd.div_start)
				dcnt_q <= DCW'(W);
			else if (dcnt_q != '0)
				dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= number;
			cand_q <= CW'(1);
			sq_q   <= SW'(1);
		end else if (cmd.advance) begin
			cand_q <= cand_q + 1'b1;
			// (c+1)^2 = c^2 + 2c + 1
			sq_q   <= sq_q + SW'({cand_q, 1'b1});
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= n_q;
		end else if (dcnt_q != '0) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[sp_q[AW-1:0]] <= quo_q;
		if (cmd.pop_read)
			pop_q <= mem[sp_dec[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cand || cmd.emit_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cand) begin
			out_divisor_q <= cand_ext;
			out_last_q    <= cand_ext == n_q;
		end else if (cmd.emit_pop) begin
			out_divisor_q <= pop_q;
			out_last_q    <= pop_q == n_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_divisor = out_divisor_q;
	assign out_last    = out_last_q;

endmodule
`default_nettype wire

[hdl/dla_ctrl.sv]
// Controller: sequences the candidate scan, the trial divisions and the
// cofactor pops. Depends on dla_pkg.
`default_nettype none
module dla_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire dla_pkg::dla_status_t status,
	output dla_pkg::dla_cmd_t         cmd
);
	import dla_pkg::*;

	dla_state_t state_q;
	dla_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_zero ? ST_IDLE : ST_TEST;
				end
			end
			ST_TEST: begin
				if (status.sq_over) begin
					state_d = ST_POP;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!status.div_busy)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!status.rem_zero) begin
					cmd.advance = 1'b1;
					state_d     = ST_TEST;
				end else if (!status.res_room || status.out_free) begin
					// hold while the output word is still waiting
					cmd.emit_cand = status.res_room;
					cmd.push      = status.quo_ne_cand && status.stack_room;
					cmd.advance   = 1'b1;
					state_d       = ST_TEST;
				end
			end
			ST_POP: begin
				if (status.stack_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.pop_read = 1'b1;
					state_d      = ST_POPW;
				end
			end
			ST_POPW: begin
				if (!status.res_room || status.out_free) begin
					cmd.emit_pop = status.res_room;
					state_d      = ST_POP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[hdl/divisor_list_ascending.sv]
// Top level of the ascending divisor lister: controller plus datapath.
// Depends on dla_pkg, dla_in_if, dla_out_if, dla_ctrl, dla_datapath.
//
//   channel   dir   words                 handshake
//   request   in    number                valid/ready
//   result    out   divisor, last         valid/ready
//
// One number at a time; request.ready is high only between runs.
// Each candidate c with c*c <= number goes through a trial division by the
// one-bit-per-cycle divider and a check; each stacked cofactor takes a memory read, then an emit.
// A stalled result holds the scan only when the next divisor is due.
// Reset clears the sequencer and counters; the stack needs no clearing.
`default_nettype none
module divisor_list_ascending #(
	parameter int NUMBER_WIDTH = 12,
	parameter int STACK_DEPTH  = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	dla_in_if.sink   request,
	dla_out_if.source result
);
	import dla_pkg::*;

	dla_cmd_t    cmd;
	dla_status_t status;
	logic        in_ready;

	dla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	dla_datapath #(
		.NUMBER_WIDTH (NUMBER_WIDTH),
		.STACK_DEPTH  (STACK_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.number      (request.number),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_divisor (result.divisor),
		.out_last    (result.last)
	);

	assign request.ready = in_ready;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Testbench for divisor_list_ascending: directed and random numbers, checked word by word.
// Depends on dla_pkg, dla_in_if, dla_out_if and the divisor_list_ascending RTL.
`default_nettype none
module testbench;

	localparam int NW          = 12;
	localparam int DEPTH       = 24;
	localparam int N_DIRECTED  = 20;
	localparam int N_RANDOM    = 80;
	localparam int HOLD_CYCLES = 2500;
	localparam int DRAIN       = 1100;
	localparam int LIMIT       = 800000;

	typedef struct packed {
		logic [NW-1:0] divisor;
		logic          last;
	} divisor_word_t;

	typedef struct packed {
		logic [NW-1:0]       number;
		logic                is_typed;
		logic [2:0]          n_typed;
		logic [0:3][NW-1:0]  typed_div;
	} directed_row_t;

	// Short lists are typed in; the rest come from the divisor predictor.
	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{12'd0,    1'b1, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd1,    1'b1, 3'd1, '{12'd1, 12'd0, 12'd0, 12'd0}},
		'{12'd2,    1'b1, 3'd2, '{12'd1, 12'd2, 12'd0, 12'd0}},
		'{12'd3,    1'b1, 3'd2, '{12'd1, 12'd3, 12'd0, 12'd0}},
		'{12'd4,    1'b1, 3'd3, '{12'd1, 12'd2, 12'd4, 12'd0}},
		'{12'd9,    1'b1, 3'd3, '{12'd1, 12'd3, 12'd9, 12'd0}},
		'{12'd4093, 1'b1, 3'd2, '{12'd1, 12'd4093, 12'd0, 12'd0}},
		'{12'd0,    1'b1, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd0,    1'b1, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd4095, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd2048, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd3969, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd3360, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd2520, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd2730, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd1365, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd3600, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd4094, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd1024, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}},
		'{12'd4032, 1'b0, 3'd0, '{12'd0, 12'd0, 12'd0, 12'd0}}
	};

	logic clk;
	logic arst_n;

	dla_in_if  #(.NUMBER_WIDTH(NW)) req_if ();
	dla_out_if #(.NUMBER_WIDTH(NW)) res_if ();

	divisor_list_ascending #(
		.NUMBER_WIDTH(NW),
		.STACK_DEPTH (DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if),
		.result (res_if)
	);

	divisor_word_t pending_divisors [$];
	int            numbers_sent;
	int            words_checked;
	int            mismatches;
	int            cycle_count;
	int            hold_left;
	bit            hold_done;
	bit            calm;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.number = '0;
		res_if.ready = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic void queue_divisor(input int unsigned value, input int unsigned whole);
		divisor_word_t w;
		w.divisor = value[NW-1:0];
		w.last    = (value == whole);
		pending_divisors = {pending_divisors, w};
	endfunction

	// Ascending divisors: small ones during the scan, stacked cofactors popped after.
	function automatic void predict_divisors(input logic [NW-1:0] number);
		int unsigned n;
		int unsigned c;
		int unsigned produced;
		int unsigned cofactors [$];
		n = 32'(number);
		produced = 0;
		if (n == 0)
			return;
		for (c = 1; c * c <= n; c++) begin
			if (n % c == 0) begin
				if (produced < dla_pkg::MAX_RESULTS) begin
					queue_divisor(c, n);
					produced++;
				end
				if (n / c != c && cofactors.size() < DEPTH)
					cofactors = {cofactors, n / c};
			end
		end
		while (cofactors.size() != 0) begin
			c = cofactors.pop_back();
			if (produced < dla_pkg::MAX_RESULTS) begin
				queue_divisor(c, n);
				produced++;
			end
		end
	endfunction

	// Mostly uniform, with a share of small, highly composite and square numbers.
	function automatic logic [NW-1:0] pick_number();
		int unsigned sel;
		int unsigned k;
		sel = $urandom_range(99);
		if (sel < 60)
			return NW'($urandom_range(4095));
		if (sel < 75)
			return NW'($urandom_range(63));
		if (sel < 90) begin
			case ($urandom_range(7))
				0: return 12'd3360;
				1: return 12'd2520;
				2: return 12'd1680;
				3: return 12'd2880;
				4: return 12'd3600;
				5: return 12'd4032;
				6: return 12'd3024;
				default: return 12'd2160;
			endcase
		end
		k = $urandom_range(63, 1);
		return NW'(k * k);
	endfunction

	task automatic send_number(input logic [NW-1:0] number);
		while (!calm && $urandom_range(99) < 38) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.number <= number;
		do
			@(posedge clk);
		while (!req_if.ready);
		numbers_sent++;
	endtask

	initial begin
		directed_row_t row;
		logic [NW-1:0] number;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			send_number(row.number);
			if (row.is_typed) begin
				for (int j = 0; j < int'(row.n_typed); j++)
					queue_divisor(32'(row.typed_div[j]), 32'(row.number));
			end else begin
				predict_divisors(row.number);
			end
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 40 && i < 60);
			number = pick_number();
			send_number(number);
			predict_divisors(number);
		end
		calm = 1'b0;
		req_if.valid <= 1'b0;
		while (pending_divisors.size() != 0)
			@(posedge clk);
		// Let any stray word from the last run show up.
		repeat (DRAIN) @(posedge clk);
		$display("Covered %0d numbers (%0d directed, %0d random), %0d divisor words checked,",
			numbers_sent, N_DIRECTED, N_RANDOM, words_checked);
		$display("random gaps on both sides and one result stall of %0d cycles.", HOLD_CYCLES);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off to back up the block.
	initial begin
		hold_left = 0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && numbers_sent >= N_DIRECTED + 15) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= calm || ($urandom_range(99) >= 38);
			end
		end
	end

	always @(posedge clk) begin
		divisor_word_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_divisors.size() == 0) begin
				$error("unexpected word: divisor %0d last %0d", res_if.divisor, res_if.last);
				mismatches++;
			end else begin
				want = pending_divisors.pop_front();
				words_checked++;
				if (res_if.divisor !== want.divisor) begin
					$error("divisor: expected %0d, got %0d", want.divisor, res_if.divisor);
					mismatches++;
				end
				if (res_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, res_if.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending",
				cycle_count, pending_divisors.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
`default_nettype wire

[sim.f]
hdl/dla_pkg.sv
hdl/dla_in_if.sv
hdl/dla_out_if.sv
hdl/dla_datapath.sv
hdl/dla_ctrl.sv
hdl/divisor_list_ascending.sv
bench/testbench.sv
